>>> src/uqpd_pkg.sv
// Shared types, constants and decode functions for the URL query pair decoder.
package uqpd_pkg;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;

  localparam logic [9:0] RAW_SAT   = 10'h3FF;
  localparam logic [7:0] PAIRS_SAT = 8'hFF;

  localparam logic [7:0] RST_MAX_KEY   = 8'd63;
  localparam logic [9:0] RST_MAX_VALUE = 10'd255;
  localparam logic [9:0] RST_MAX_RAW   = 10'd383;
  localparam logic [7:0] RST_MAX_PAIRS = 8'd64;

  localparam int QDEPTH = 4;
  localparam int QPW    = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    REG_MAX_KEY   = 2'd0,
    REG_MAX_VALUE = 2'd1,
    REG_MAX_RAW   = 2'd2,
    REG_MAX_PAIRS = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] max_key_bytes;
    logic [9:0] max_value_bytes;
    logic [9:0] max_raw_pair_bytes;
    logic [7:0] max_pair_count;
  } cfg_t;

  typedef struct packed {
    logic [7:0] query_byte;
    logic       is_final;
  } in_item_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] decoded_byte;
    logic       in_value_part;
    logic       pair_done;
    logic [7:0] pair_number;
    logic       query_done;
  } out_item_t;

  // Up to three results caused by one input byte, in delivery order.
  typedef struct packed {
    out_item_t [2:0] slot;
    logic [1:0]      count;
  } res_group_t;

  typedef struct packed {
    logic       full;
    logic       empty;
  } q_status_t;

  typedef struct packed {
    logic [1:0] hold_count;
    logic [7:0] escape_hold;
    logic [9:0] raw_position;
    logic [7:0] key_count;
    logic [9:0] value_count;
    logic       seen_equals;
    logic [7:0] pairs_seen;
    logic       halted;
  } pair_state_t;

  typedef struct packed {
    pair_state_t st;
    res_group_t  grp;
  } work_t;

  // Returns {is_hex, nibble}.
  function automatic logic [4:0] hex_digit(logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= CH_0 && b <= CH_9) r = {1'b1, 4'(b - CH_0)};
    else if (b >= CH_LA && b <= CH_LF) r = {1'b1, 4'(b - CH_LA + 8'd10)};
    else if (b >= CH_UA && b <= CH_UF) r = {1'b1, 4'(b - CH_UA + 8'd10)};
    return r;
  endfunction

  function automatic work_t emit(work_t w, logic v, logic [7:0] b, logic iv, logic pd,
                                 logic qd);
    work_t     r;
    out_item_t it;
    r = w;
    it.byte_valid    = v;
    it.decoded_byte  = b;
    it.in_value_part = iv;
    it.pair_done     = pd;
    it.pair_number   = w.st.pairs_seen;
    it.query_done    = qd;
    if (w.grp.count != 2'd3) begin
      r.grp.slot[w.grp.count] = it;
      r.grp.count = w.grp.count + 2'd1;
    end
    return r;
  endfunction

  function automatic logic part_full(work_t w, cfg_t c);
    return w.st.seen_equals ? (w.st.value_count >= c.max_value_bytes)
                            : (w.st.key_count >= c.max_key_bytes);
  endfunction

  function automatic work_t put_byte(work_t w, logic [7:0] b, cfg_t c);
    work_t r;
    r = w;
    if (!part_full(w, c)) begin
      if (w.st.seen_equals) r.st.value_count = w.st.value_count + 10'd1;
      else r.st.key_count = w.st.key_count + 8'd1;
      r = emit(r, 1'b1, b, w.st.seen_equals, 1'b0, 1'b0);
    end
    return r;
  endfunction

  function automatic work_t put_plain(work_t w, logic [7:0] b, cfg_t c);
    return put_byte(w, (b == CH_PLUS) ? CH_SPACE : b, c);
  endfunction

  // Feed for the states with no escape or a bare '%' pending.
  function automatic work_t feed_low(work_t w, logic [7:0] b, cfg_t c);
    work_t r;
    r = w;
    if (w.st.hold_count == 2'd0) begin
      if (!part_full(w, c)) begin
        if (b == CH_PCT) r.st.hold_count = 2'd1;
        else r = put_plain(w, b, c);
      end
    end else begin
      r.st.escape_hold = b;
      r.st.hold_count  = 2'd2;
    end
    return r;
  endfunction

  function automatic work_t feed(work_t w, logic [7:0] b, cfg_t c);
    work_t      r;
    logic [4:0] hi;
    logic [4:0] lo;
    logic [7:0] first;
    r = w;
    if (w.st.hold_count == 2'd0 || w.st.hold_count == 2'd1) begin
      r = feed_low(w, b, c);
    end else begin
      hi    = hex_digit(w.st.escape_hold);
      lo    = hex_digit(b);
      first = w.st.escape_hold;
      r.st.hold_count  = 2'd0;
      r.st.escape_hold = 8'd0;
      if (hi[4] && lo[4]) begin
        r = put_byte(r, {hi[3:0], lo[3:0]}, c);
      end else begin
        r = feed_low(r, first, c);
        r = feed_low(r, b, c);
      end
    end
    return r;
  endfunction

  // Ends a pending escape literally, as at the end of a part.
  function automatic work_t flush_part(work_t w, cfg_t c);
    work_t r;
    r = w;
    r.st.hold_count  = 2'd0;
    r.st.escape_hold = 8'd0;
    if (w.st.hold_count != 2'd0) r = put_byte(r, CH_PCT, c);
    if (w.st.hold_count[1]) r = put_plain(r, w.st.escape_hold, c);
    return r;
  endfunction

  function automatic work_t close_pair(work_t w, logic qd, cfg_t c);
    work_t r;
    r = flush_part(w, c);
    r = emit(r, 1'b0, 8'd0, 1'b0, 1'b1, qd);
    if (r.st.pairs_seen != PAIRS_SAT) r.st.pairs_seen = r.st.pairs_seen + 8'd1;
    if (r.st.pairs_seen >= c.max_pair_count) r.st.halted = 1'b1;
    r.st.hold_count   = 2'd0;
    r.st.escape_hold  = 8'd0;
    r.st.raw_position = 10'd0;
    r.st.key_count    = 8'd0;
    r.st.value_count  = 10'd0;
    r.st.seen_equals  = 1'b0;
    return r;
  endfunction

endpackage

>>> src/url_query_pair_decoder.sv
// Top level of the streaming URL query string pair splitter and percent decoder.
//
// Raw query bytes enter at one per clock cycle while the queue is not full; each accepted
// byte is split, decoded and turned at once into a group of zero to three results. A group
// with at least one result waits in a four-group queue until the output stage hands its
// results out one per cycle while out_stall_i is low. A byte may give several results (an
// ending pair with a pending escape, for instance), and the input stalls only
// when the four-group queue is full. There is no clearing pass after reset. The limit
// registers may be written at any index through the configuration port, which is always
// ready; write them only while no transaction is in flight.
module url_query_pair_decoder
  import uqpd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  in_item_t  in_data_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  output out_item_t out_data_o,
  input  logic      out_stall_i,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [9:0] cfg_data_i
);

  cfg_t       cfg;
  q_status_t  q_stat;
  logic       q_push;
  logic       q_pop;
  res_group_t push_grp;
  res_group_t head_grp;

  uqpd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  uqpd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .q_stat_i   (q_stat),
    .push_o     (q_push),
    .grp_o      (push_grp)
  );

  uqpd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_grp),
    .pop_i       (q_pop),
    .head_o      (head_grp),
    .stat_o      (q_stat)
  );

  uqpd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_grp),
    .q_stat_i    (q_stat),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTH
  // The front end must never push into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_stat.full)
    else $error("result group pushed into a full queue");

  // Groups in the queue always carry at least one result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (head_grp.count != 2'd0))
    else $error("empty result group at the queue head");

  // A pair marker never carries a data byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.pair_done) |-> !out_data_o.byte_valid)
    else $error("pair marker carries a data byte");
`endif

endmodule

>>> src/uqpd_cfg_regs.sv
// Configuration register file for the limits of the query pair decoder.
module uqpd_cfg_regs
  import uqpd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [9:0] cfg_data_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_MAX_KEY:   cfg_d.max_key_bytes      = cfg_data_i[7:0];
        REG_MAX_VALUE: cfg_d.max_value_bytes    = cfg_data_i;
        REG_MAX_RAW:   cfg_d.max_raw_pair_bytes = cfg_data_i;
        REG_MAX_PAIRS: cfg_d.max_pair_count     = cfg_data_i[7:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_key_bytes      <= RST_MAX_KEY;
      cfg_q.max_value_bytes    <= RST_MAX_VALUE;
      cfg_q.max_raw_pair_bytes <= RST_MAX_RAW;
      cfg_q.max_pair_count     <= RST_MAX_PAIRS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> src/uqpd_front.sv
// Front end: accepts raw bytes, tracks pair state and builds the result group per byte.
module uqpd_front
  import uqpd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  input  in_item_t   in_data_i,
  output logic       in_stall_o,
  input  q_status_t  q_stat_i,
  output logic       push_o,
  output res_group_t grp_o
);

  pair_state_t st_q;
  pair_state_t st_d;
  work_t       w;
  logic        closed;
  logic        accept;
  logic [7:0]  b;
  logic        fin;

  assign b          = in_data_i.query_byte;
  assign fin        = in_data_i.is_final;
  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !q_stat_i.full;

  always_comb begin
    w.st   = st_q;
    w.grp  = '0;
    closed = 1'b0;
    if (!st_q.halted && st_q.pairs_seen < cfg_i.max_pair_count) begin
      if (b != CH_AMP) begin
        if (w.st.raw_position < cfg_i.max_raw_pair_bytes) begin
          w.st.raw_position = w.st.raw_position + 10'd1;
          if (!w.st.seen_equals && b == CH_EQ) begin
            w = flush_part(w, cfg_i);
            w.st.seen_equals = 1'b1;
          end else begin
            w = feed(w, b, cfg_i);
          end
          // The last byte within the raw limit also ends any pending escape.
          if (w.st.raw_position == cfg_i.max_raw_pair_bytes) w = flush_part(w, cfg_i);
        end else if (w.st.raw_position != RAW_SAT) begin
          w.st.raw_position = w.st.raw_position + 10'd1;
        end
      end
      if ((b == CH_AMP || fin) && w.st.raw_position != 10'd0) begin
        w      = close_pair(w, fin, cfg_i);
        closed = 1'b1;
      end
    end
    if (fin) begin
      if (!closed) w = emit(w, 1'b0, 8'd0, 1'b0, 1'b0, 1'b1);
      w.st = '0;
    end
    st_d = accept ? w.st : st_q;
  end

  assign push_o = accept && (w.grp.count != 2'd0);
  assign grp_o  = w.grp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

endmodule

>>> src/uqpd_queue.sv
// Short queue of result groups between the front end and the output stage.
module uqpd_queue
  import uqpd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  res_group_t push_data_i,
  input  logic       pop_i,
  output res_group_t head_o,
  output q_status_t  stat_o
);

  res_group_t          mem_q [QDEPTH];
  logic [QPW-1:0]      wr_ptr_q;
  logic [QPW-1:0]      rd_ptr_q;
  logic [QPW:0]        fill_q;
  logic [QPW:0]        fill_d;
  logic                do_push;
  logic                do_pop;

  assign stat_o.full  = (fill_q == (QPW + 1)'(QDEPTH));
  assign stat_o.empty = (fill_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    fill_d = fill_q;
    if (do_push && !do_pop) fill_d = fill_q + (QPW + 1)'(1);
    else if (do_pop && !do_push) fill_d = fill_q - (QPW + 1)'(1);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + QPW'(1);
      if (do_pop) rd_ptr_q <= rd_ptr_q + QPW'(1);
      fill_q <= fill_d;
    end
  end

endmodule

>>> src/uqpd_back.sv
// Output stage: hands out the results of the queued group one per transaction.
module uqpd_back
  import uqpd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  res_group_t head_i,
  input  q_status_t  q_stat_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_data_o
);

  logic [1:0] idx_q;
  logic [1:0] idx_d;
  logic       take;
  logic       last;

  assign out_valid_o = !q_stat_i.empty;
  assign out_data_o  = head_i.slot[idx_q];
  assign take        = out_valid_o && !out_stall_i;
  assign last        = (idx_q == head_i.count - 2'd1);
  assign pop_o       = take && last;

  always_comb begin
    idx_d = idx_q;
    if (take) idx_d = last ? 2'd0 : idx_q + 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule
